// ===== hdl/mea_pkg.sv =====
// Shared types and constants for the modular element ALU.
package mea_pkg;

  localparam int unsigned WORD_BITS  = 60;
  localparam int unsigned SHIFT_BITS = 128;
  localparam int unsigned CNT_BITS   = $clog2(SHIFT_BITS);
  localparam int unsigned LOOP_BITS  = $clog2(WORD_BITS);
  localparam int unsigned LAST_RED   = WORD_BITS - 1;
  localparam int unsigned LAST_MUL   = 2 * WORD_BITS - 1;
  localparam int unsigned LAST_WIDE  = SHIFT_BITS - 1;
  localparam int unsigned CFG_BITS   = 2;

  localparam logic [3:0] KIND_ADD     = 4'd0;
  localparam logic [3:0] KIND_SUB     = 4'd1;
  localparam logic [3:0] KIND_MUL     = 4'd2;
  localparam logic [3:0] KIND_EXP     = 4'd3;
  localparam logic [3:0] KIND_INV     = 4'd4;
  localparam logic [3:0] KIND_SWITCH  = 4'd5;
  localparam logic [3:0] KIND_CREDUCE = 4'd6;
  localparam logic [3:0] KIND_MULRND  = 4'd7;
  localparam logic [3:0] KIND_DIVRND  = 4'd8;

  localparam logic [CFG_BITS-1:0] REG_MODULUS   = 2'd0;
  localparam logic [CFG_BITS-1:0] REG_TARGET    = 2'd1;
  localparam logic [CFG_BITS-1:0] REG_ROUND_NUM = 2'd2;
  localparam logic [CFG_BITS-1:0] REG_ROUND_DEN = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_STEP, OP_SAVE_N, OP_MUL_INIT_NB, OP_MUL_DBL,
    OP_MUL_ADD, OP_EXP_INIT, OP_MUL_INIT_SQ, OP_MUL_INIT_BASE, OP_EXP_TAKE,
    OP_EXP_SHIFT, OP_EU_INIT, OP_EU_DIV_LOAD, OP_EU_MUL_INIT, OP_EU_UPDATE,
    OP_SW_LOAD_N, OP_SW_MID, OP_RD_INIT, OP_PROD_STEP, OP_CLR_R, OP_RD_ADJ,
    OP_FIN
  } op_t;

  typedef enum logic [1:0] {DSEL_M, DSEL_NM, DSEL_D, DSEL_R1} dsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_N, S_SAVE_N, S_RED_B, S_MUL2_INIT, S_MUL, S_EXP_INIT,
    S_EXP_SQ, S_EXP_AFTER, S_EXP_BASE, S_EXP_NEXT, S_EU_INIT, S_EU_TEST,
    S_EU_DIV, S_EU_MUL_INIT, S_EU_UPDATE, S_SW_LOAD, S_SW_RED1, S_SW_MID,
    S_SW_RED2, S_RD_INIT, S_RD_PROD, S_RD_CLR, S_RD_DIV, S_RD_ADJ, S_RD_RED,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       e_msb;
    logic       r1_zero;
  } status_t;

endpackage

// ===== hdl/mea_dp.sv =====
// Datapath: shared serial divider/reducer, serial modular multiplier, operand registers.
module mea_dp (
  input  logic                          clk,
  input  mea_pkg::cmd_t                 cmd,
  output mea_pkg::status_t              status,
  input  logic                          cfg_write,
  input  logic [mea_pkg::CFG_BITS-1:0]  cfg_index,
  input  logic [mea_pkg::WORD_BITS-1:0] cfg_data,
  input  logic                          rst,
  input  logic [3:0]                    kind,
  input  logic [mea_pkg::WORD_BITS-1:0] value,
  input  logic [mea_pkg::WORD_BITS-1:0] operand,
  input  logic                          last_in,
  output logic [mea_pkg::WORD_BITS-1:0] result,
  output logic                          error,
  output logic                          last_out
);
  import mea_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned SW = SHIFT_BITS;

  logic [W-1:0]  modulus, target_modulus, round_numerator, round_denominator;
  logic [W-1:0]  m, nm, d, half;
  logic [3:0]    kind_q;
  logic          last_q;
  logic [W-1:0]  n, b, e, er;
  logic [SW-1:0] s;
  logic [W-1:0]  r;
  logic [W-1:0]  ma, mb, acc;
  logic [W-1:0]  r0, r1, t0, t1;

  logic [W-1:0]  div;
  logic [W:0]    t;
  logic          ge;
  logic [W:0]    msum;
  logic [W-1:0]  mred;
  logic [W-1:0]  q, qm, nt, x, p, res_fin;
  logic          err_fin, neg;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus           <= W'(2);
      target_modulus    <= W'(2);
      round_numerator   <= W'(1);
      round_denominator <= W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODULUS:   modulus           <= cfg_data;
        REG_TARGET:    target_modulus    <= cfg_data;
        REG_ROUND_NUM: round_numerator   <= cfg_data;
        REG_ROUND_DEN: round_denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    m    = (modulus < W'(2)) ? W'(2) : modulus;
    nm   = (target_modulus < W'(2)) ? W'(2) : target_modulus;
    d    = (round_denominator == '0) ? W'(1) : round_denominator;
    half = m >> 1;
    neg  = n > half;
    x    = neg ? m - n : n;
    p    = (kind_q == KIND_MULRND) ? round_numerator : W'(1);

    case (cmd.dsel)
      DSEL_M:  div = m;
      DSEL_NM: div = nm;
      DSEL_D:  div = d;
      default: div = r1;
    endcase
    t  = {r, s[SW-1]};
    ge = t >= {1'b0, div};

    // one modular add: acc+acc or acc+ma
    msum = (cmd.op == OP_MUL_DBL) ? {1'b0, acc} + {1'b0, acc} : {1'b0, acc} + {1'b0, ma};
    mred = (msum >= {1'b0, m}) ? W'(msum - {1'b0, m}) : msum[W-1:0];

    q  = s[W-1:0];
    qm = (q >= m) ? q - m : q;
    nt = (t0 >= acc) ? t0 - acc : t0 + (m - acc);

    err_fin = 1'b0;
    case (kind_q)
      KIND_ADD: begin
        res_fin = (({1'b0, n} + {1'b0, r}) >= {1'b0, m}) ? W'({1'b0, n} + {1'b0, r} - {1'b0, m})
                                                           : n + r;
      end
      KIND_SUB: res_fin = (n >= r) ? n - r : n + (m - r);
      KIND_MUL: res_fin = acc;
      KIND_EXP: res_fin = er;
      KIND_INV: begin
        err_fin = (r0 != W'(1));
        res_fin = err_fin ? '0 : t0;
      end
      KIND_SWITCH, KIND_CREDUCE: begin
        if (kind_q == KIND_CREDUCE && nm == W'(2))
          res_fin = W'(n[0] ^ neg);
        else if (neg)
          res_fin = (b >= r) ? b - r : b + (nm - r);
        else
          res_fin = b;
      end
      KIND_MULRND, KIND_DIVRND: res_fin = (neg && r != '0) ? m - r : r;
      default: res_fin = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_q <= kind;
        last_q <= last_in;
        b      <= operand;
        s      <= {value, {(SW-W){1'b0}}};
        r      <= '0;
      end
      OP_DIV_STEP: begin
        r <= ge ? W'(t - {1'b0, div}) : t[W-1:0];
        s <= {s[SW-2:0], ge};
      end
      OP_SAVE_N: begin
        n <= r;
        s <= {b, {(SW-W){1'b0}}};
        r <= '0;
      end
      OP_MUL_INIT_NB: begin
        ma <= n; mb <= r; acc <= '0;
      end
      OP_MUL_DBL: acc <= mred;
      OP_MUL_ADD: begin
        if (mb[W-1]) acc <= mred;
        mb <= mb << 1;
      end
      OP_EXP_INIT: begin
        er <= W'(1); e <= b;
      end
      OP_MUL_INIT_SQ: begin
        ma <= er; mb <= er; acc <= '0;
      end
      OP_MUL_INIT_BASE: begin
        ma <= n; mb <= er; acc <= '0;
      end
      OP_EXP_TAKE:  er <= acc;
      OP_EXP_SHIFT: e  <= e << 1;
      OP_EU_INIT: begin
        r0 <= m; r1 <= n; t0 <= '0; t1 <= W'(1);
      end
      OP_EU_DIV_LOAD: begin
        s <= {r0, {(SW-W){1'b0}}};
        r <= '0;
      end
      OP_EU_MUL_INIT: begin
        ma <= qm; mb <= t1; acc <= '0;
      end
      OP_EU_UPDATE: begin
        r0 <= r1; r1 <= r; t0 <= t1; t1 <= nt;
      end
      OP_SW_LOAD_N: begin
        s <= {n, {(SW-W){1'b0}}};
        r <= '0;
      end
      OP_SW_MID: begin
        b <= r;
        s <= {m, {(SW-W){1'b0}}};
        r <= '0;
      end
      OP_RD_INIT: begin
        ma <= x; mb <= p; s <= '0;
      end
      OP_PROD_STEP: begin
        s  <= (s << 1) + (mb[W-1] ? SW'(ma) : SW'(0));
        mb <= mb << 1;
      end
      OP_CLR_R: r <= '0;
      OP_RD_ADJ: begin
        s <= s + SW'(r > (d >> 1));
        r <= '0;
      end
      OP_FIN: begin
        result   <= res_fin;
        error    <= err_fin;
        last_out <= last_q;
      end
      default: ;
    endcase
  end

  assign status.kind    = kind_q;
  assign status.e_msb   = e[W-1];
  assign status.r1_zero = (r1 == '0);

endmodule

// ===== hdl/mea_ctrl.sv =====
// Controller: sequences datapath operations per operation kind and owns the handshakes.
module mea_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mea_pkg::status_t status,
  output mea_pkg::cmd_t    cmd
);
  import mea_pkg::*;

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic [LOOP_BITS-1:0]  lcnt, lcnt_next;
  logic                  sq, sq_next;
  logic                  out_valid_next;
  logic                  out_free;
  logic                  red_last, mul_last, wide_last;

  assign out_free  = !out_valid || out_ready;
  assign red_last  = (cnt == CNT_BITS'(LAST_RED));
  assign mul_last  = (cnt == CNT_BITS'(LAST_MUL));
  assign wide_last = (cnt == CNT_BITS'(LAST_WIDE));
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      lcnt      <= '0;
      sq        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      lcnt      <= lcnt_next;
      sq        <= sq_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt + CNT_BITS'(1);
    lcnt_next      = lcnt;
    sq_next        = sq;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NONE;
    cmd.dsel       = DSEL_M;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_RED_N;
        end
      end
      S_RED_N: begin
        cmd.op = OP_DIV_STEP;
        if (red_last) state_next = S_SAVE_N;
      end
      S_SAVE_N: begin
        cmd.op   = OP_SAVE_N;
        cnt_next = '0;
        case (status.kind) inside
          KIND_ADD, KIND_SUB, KIND_MUL: state_next = S_RED_B;
          KIND_EXP:                     state_next = S_EXP_INIT;
          KIND_INV:                     state_next = S_EU_INIT;
          KIND_SWITCH, KIND_CREDUCE:    state_next = S_SW_LOAD;
          KIND_MULRND, KIND_DIVRND:     state_next = S_RD_INIT;
          default:                      state_next = S_FIN;
        endcase
      end
      S_RED_B: begin
        cmd.op = OP_DIV_STEP;
        if (red_last) state_next = (status.kind == KIND_MUL) ? S_MUL2_INIT : S_FIN;
      end
      S_MUL2_INIT: begin
        cmd.op     = OP_MUL_INIT_NB;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        // even cycles double, odd cycles conditionally add
        cmd.op = cnt[0] ? OP_MUL_ADD : OP_MUL_DBL;
        if (mul_last) begin
          case (status.kind)
            KIND_EXP: state_next = S_EXP_AFTER;
            KIND_INV: state_next = S_EU_UPDATE;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_EXP_INIT: begin
        cmd.op     = OP_EXP_INIT;
        lcnt_next  = '0;
        state_next = S_EXP_SQ;
      end
      S_EXP_SQ: begin
        cmd.op     = OP_MUL_INIT_SQ;
        cnt_next   = '0;
        sq_next    = 1'b1;
        state_next = S_MUL;
      end
      S_EXP_AFTER: begin
        cmd.op     = OP_EXP_TAKE;
        state_next = (sq && status.e_msb) ? S_EXP_BASE : S_EXP_NEXT;
      end
      S_EXP_BASE: begin
        cmd.op     = OP_MUL_INIT_BASE;
        cnt_next   = '0;
        sq_next    = 1'b0;
        state_next = S_MUL;
      end
      S_EXP_NEXT: begin
        cmd.op     = OP_EXP_SHIFT;
        lcnt_next  = lcnt + LOOP_BITS'(1);
        state_next = (lcnt == LOOP_BITS'(LAST_RED)) ? S_FIN : S_EXP_SQ;
      end
      S_EU_INIT: begin
        cmd.op     = OP_EU_INIT;
        state_next = S_EU_TEST;
      end
      S_EU_TEST: begin
        cnt_next = '0;
        if (status.r1_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_EU_DIV_LOAD;
          state_next = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cmd.dsel = DSEL_R1;
        if (red_last) state_next = S_EU_MUL_INIT;
      end
      S_EU_MUL_INIT: begin
        cmd.op     = OP_EU_MUL_INIT;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_EU_UPDATE: begin
        cmd.op     = OP_EU_UPDATE;
        state_next = S_EU_TEST;
      end
      S_SW_LOAD: begin
        cmd.op     = OP_SW_LOAD_N;
        cnt_next   = '0;
        state_next = S_SW_RED1;
      end
      S_SW_RED1: begin
        cmd.op   = OP_DIV_STEP;
        cmd.dsel = DSEL_NM;
        if (red_last) state_next = S_SW_MID;
      end
      S_SW_MID: begin
        cmd.op     = OP_SW_MID;
        cnt_next   = '0;
        state_next = S_SW_RED2;
      end
      S_SW_RED2: begin
        cmd.op   = OP_DIV_STEP;
        cmd.dsel = DSEL_NM;
        if (red_last) state_next = S_FIN;
      end
      S_RD_INIT: begin
        cmd.op     = OP_RD_INIT;
        cnt_next   = '0;
        state_next = S_RD_PROD;
      end
      S_RD_PROD: begin
        cmd.op = OP_PROD_STEP;
        if (red_last) state_next = S_RD_CLR;
      end
      S_RD_CLR: begin
        cmd.op     = OP_CLR_R;
        cnt_next   = '0;
        state_next = S_RD_DIV;
      end
      S_RD_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cmd.dsel = DSEL_D;
        if (wide_last) state_next = S_RD_ADJ;
      end
      S_RD_ADJ: begin
        cmd.op     = OP_RD_ADJ;
        cnt_next   = '0;
        state_next = S_RD_RED;
      end
      S_RD_RED: begin
        cmd.op = OP_DIV_STEP;
        if (wide_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RED_N))
    else $error("accepted item did not start reduction");

  a_fin_presents: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_mul_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && mul_last) |=> (state != S_MUL))
    else $error("multiplier ran past its last step");

endmodule

// ===== hdl/modular_element_alu.sv =====
// Top level of the modular element ALU: controller plus datapath.
// Throughput: one item at a time; the next transfer is taken once the result is
//   in the output register. The bit-serial divider/reducer and the serial
//   double-and-add multiplier set the processing time of each item; the inverse
//   runs extended Euclid steps, each with one division and one multiplication.
// Reset (rst, synchronous, active high): controller idle, no output pending,
//   modulus and target 2, round numerator and denominator 1.
module modular_element_alu (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [mea_pkg::CFG_BITS-1:0]  cfg_index,
  input  logic [mea_pkg::WORD_BITS-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    kind,
  input  logic [mea_pkg::WORD_BITS-1:0] value,
  input  logic [mea_pkg::WORD_BITS-1:0] operand,
  input  logic                          last_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mea_pkg::WORD_BITS-1:0] result,
  output logic                          error,
  output logic                          last_out
);
  import mea_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one state per phase, a shared step counter for serial loops.
  mea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: config registers, operand registers, divider/reducer, multiplier,
  // and the output register loaded on the final step of each item.
  mea_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rst       (rst),
    .kind      (kind),
    .value     (value),
    .operand   (operand),
    .last_in   (last_in),
    .result    (result),
    .error     (error),
    .last_out  (last_out)
  );

endmodule
